@@ design/rtsc_pkg.sv @@
// Shared types and constants for the rule-table state classifier.
// Holds the beat layouts, the register layouts and the rule kind codes.
// No dependencies.
package rtsc_pkg;

  localparam int RULE_SLOTS   = 4;
  localparam int STATE_COUNT  = 8;
  localparam int VALUE_BITS   = 16;
  localparam int STATE_BITS   = 3;
  localparam int ACTION_BITS  = 3;
  localparam int TIME_BITS    = 24;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_BYTES_BITS = 64;
  localparam int OUT_BYTES_BITS = 8;

  // Rule kinds held in bits 2:0 of a rule slot.
  typedef enum logic [2:0] {
    KIND_OFF     = 3'd0,
    KIND_GTE     = 3'd1,
    KIND_HYST    = 3'd2,
    KIND_RATE_GT = 3'd3,
    KIND_RATE_LT = 3'd4
  } rule_kind_t;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RULE_0     = 3'd0,
    REG_RULE_1     = 3'd1,
    REG_RULE_2     = 3'd2,
    REG_RULE_3     = 3'd3,
    REG_STATE_MAP  = 3'd4,
    REG_STATE_ESC  = 3'd5,
    REG_ACTION_ESC = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] level;
    logic [STATE_BITS-1:0]        state;
    logic [2:0]                   kind;
  } rule_t;

  typedef struct packed {
    logic [7:0][ACTION_BITS-1:0] actions;
    logic [STATE_BITS-1:0]       dflt;
  } state_map_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  dur;
    logic [STATE_BITS-1:0] to;
    logic [STATE_BITS-1:0] from;
    logic                  en;
  } state_esc_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   dur;
    logic                   no_cool;
    logic [ACTION_BITS-1:0] to;
    logic [ACTION_BITS-1:0] from;
    logic                   en;
  } action_esc_t;

  typedef struct packed {
    rule_t [RULE_SLOTS-1:0] rules;
    state_map_t             map;
    state_esc_t             state_esc;
    action_esc_t            action_esc;
  } cfg_t;

  // Input beat, last field in the lowest bits.
  typedef struct packed {
    logic                         cooling_seen;
    logic [TIME_BITS-1:0]         time_in_state;
    logic [STATE_BITS-1:0]        prior_state;
    logic signed [VALUE_BITS-1:0] prior_value;
    logic signed [VALUE_BITS-1:0] sample_value;
  } sample_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0] chosen_action;
    logic [STATE_BITS-1:0]  new_state;
  } result_t;

  localparam int SAMPLE_BITS = $bits(sample_t);
  localparam int RESULT_BITS = $bits(result_t);

endpackage

@@ design/rule_table_state_classifier.sv @@
// Top level of the rule-table state classifier: stream ports, configuration
// registers, the input and result registers. Uses rtsc_pkg and rtsc_decide.
//
//  Channel  Direction  Beat contents
//  s_*      in         one sample: value, prior value, prior state, time, cooling
//  m_*      out        one result: new state and chosen action
//  cfg_*    in         one register write: index and data
//
// A sample accepted into the input register passes through the decision
// logic into the result register, which drives m_tdata. The decision logic
// between the two registers is a single pass, so a new sample is taken every
// cycle while the result side is not stalled.
// Reset is synchronous; it clears both valid flags and the configuration
// registers, while the sample and result data registers keep their contents.
// A stalled result holds in the result register while the input register
// still takes one more sample; s_tready drops only when both are full and the
// result is not being taken.
module rule_table_state_classifier (
  input  logic                               clk,
  input  logic                               rst,
  // sample_value[15:0], prior_value[31:16], prior_state[34:32],
  // time_in_state[58:35], cooling_seen[59], zero pad [63:60]
  input  logic [rtsc_pkg::IN_BYTES_BITS-1:0]  s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // new_state[2:0], chosen_action[5:3], zero pad [7:6]
  output logic [rtsc_pkg::OUT_BYTES_BITS-1:0] m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [rtsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rtsc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready
);

  rtsc_pkg::cfg_t    cfg;
  rtsc_pkg::sample_t smp;
  rtsc_pkg::result_t res;
  rtsc_pkg::result_t res_q;
  logic              smp_valid;
  logic              smp_adv;

  // Configuration writes are accepted at any time; software must write only
  // while the block is idle, and the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rtsc_pkg::reg_idx_t'(cfg_index))
        rtsc_pkg::REG_RULE_0: begin
          cfg.rules[0] <= rtsc_pkg::rule_t'(cfg_data[$bits(rtsc_pkg::rule_t)-1:0]);
        end
        rtsc_pkg::REG_RULE_1: begin
          cfg.rules[1] <= rtsc_pkg::rule_t'(cfg_data[$bits(rtsc_pkg::rule_t)-1:0]);
        end
        rtsc_pkg::REG_RULE_2: begin
          cfg.rules[2] <= rtsc_pkg::rule_t'(cfg_data[$bits(rtsc_pkg::rule_t)-1:0]);
        end
        rtsc_pkg::REG_RULE_3: begin
          cfg.rules[3] <= rtsc_pkg::rule_t'(cfg_data[$bits(rtsc_pkg::rule_t)-1:0]);
        end
        rtsc_pkg::REG_STATE_MAP: begin
          cfg.map <= rtsc_pkg::state_map_t'(cfg_data[$bits(rtsc_pkg::state_map_t)-1:0]);
        end
        rtsc_pkg::REG_STATE_ESC: begin
          cfg.state_esc <=
            rtsc_pkg::state_esc_t'(cfg_data[$bits(rtsc_pkg::state_esc_t)-1:0]);
        end
        rtsc_pkg::REG_ACTION_ESC: begin
          cfg.action_esc <=
            rtsc_pkg::action_esc_t'(cfg_data[$bits(rtsc_pkg::action_esc_t)-1:0]);
        end
        default: begin
          // Unused index: the write is taken and dropped.
        end
      endcase
    end
  end

  // The input register moves on whenever the result register is empty or
  // its beat is being taken this cycle.
  assign smp_adv  = !m_tvalid || m_tready;
  assign s_tready = !smp_valid || smp_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (s_tready) begin
      smp_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      smp <= rtsc_pkg::sample_t'(s_tdata[rtsc_pkg::SAMPLE_BITS-1:0]);
    end
  end

  rtsc_decide u_decide (
    .cfg (cfg),
    .smp (smp),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (smp_adv) begin
      m_tvalid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid && smp_adv) begin
      res_q <= res;
    end
  end

  assign m_tdata = {(rtsc_pkg::OUT_BYTES_BITS - rtsc_pkg::RESULT_BITS)'(0), res_q};

  // A sample leaving the input register always lands in the result register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (smp_valid && smp_adv) |=> m_tvalid)
    else $error("sample left the input register without a result");

  // With both registers empty the block must take a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!smp_valid && !m_tvalid) |-> s_tready)
    else $error("empty pipeline refused a sample");

  // Reset empties both the input register and the result register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !smp_valid))
    else $error("valid flag survived reset");

endmodule

@@ design/rtsc_decide.sv @@
// Combinational decision logic: rule match, state escalation, action lookup
// and action escalation for one registered sample. Uses rtsc_pkg.
module rtsc_decide (
  input  rtsc_pkg::cfg_t    cfg,
  input  rtsc_pkg::sample_t smp,
  output rtsc_pkg::result_t res
);

  logic signed [rtsc_pkg::VALUE_BITS:0]  rate;
  logic [rtsc_pkg::RULE_SLOTS-1:0]       hit;
  logic [rtsc_pkg::STATE_BITS-1:0]       base_state;
  logic [rtsc_pkg::STATE_BITS-1:0]       final_state;
  logic [rtsc_pkg::ACTION_BITS-1:0]      table_action;
  logic                                  time_ok_state;
  logic                                  time_ok_action;

  // The rate is one bit wider than the values, so it never wraps.
  assign rate = (rtsc_pkg::VALUE_BITS+1)'(smp.sample_value) -
                (rtsc_pkg::VALUE_BITS+1)'(smp.prior_value);

  // Every slot is compared in parallel.
  always_comb begin
    for (int i = 0; i < rtsc_pkg::RULE_SLOTS; i++) begin
      case (rtsc_pkg::rule_kind_t'(cfg.rules[i].kind))
        rtsc_pkg::KIND_GTE: begin
          hit[i] = smp.sample_value >= cfg.rules[i].level;
        end
        rtsc_pkg::KIND_HYST: begin
          hit[i] = (smp.prior_state == cfg.rules[i].state) &&
                   (smp.sample_value > cfg.rules[i].level);
        end
        rtsc_pkg::KIND_RATE_GT: begin
          hit[i] = rate > (rtsc_pkg::VALUE_BITS+1)'(cfg.rules[i].level);
        end
        rtsc_pkg::KIND_RATE_LT: begin
          hit[i] = rate < (rtsc_pkg::VALUE_BITS+1)'(cfg.rules[i].level);
        end
        default: begin
          hit[i] = 1'b0;
        end
      endcase
    end
  end

  // Priority pick: walking from the lowest priority up lets slot 0 win.
  always_comb begin
    base_state = cfg.map.dflt;
    for (int i = rtsc_pkg::RULE_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        base_state = cfg.rules[i].state;
      end
    end
  end

  assign time_ok_state  = smp.time_in_state >= cfg.state_esc.dur;
  assign time_ok_action = smp.time_in_state >= cfg.action_esc.dur;

  always_comb begin
    final_state = base_state;
    if (cfg.state_esc.en && base_state == cfg.state_esc.from &&
        smp.prior_state == cfg.state_esc.from && time_ok_state) begin
      final_state = cfg.state_esc.to;
    end
  end

  // States without a table entry map to no action.
  always_comb begin
    table_action = '0;
    if ({1'b0, final_state} < (rtsc_pkg::STATE_BITS+1)'(rtsc_pkg::STATE_COUNT)) begin
      table_action = cfg.map.actions[final_state];
    end
  end

  always_comb begin
    res.new_state     = final_state;
    res.chosen_action = table_action;
    if (cfg.action_esc.en && table_action == cfg.action_esc.from && time_ok_action &&
        !(cfg.action_esc.no_cool && smp.cooling_seen)) begin
      res.chosen_action = cfg.action_esc.to;
    end
  end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for rule_table_state_classifier: random and directed samples,
// register settings, and idle gaps on both stream sides.
// Depends on rtsc_pkg and the rule_table_state_classifier top level.
`timescale 1ns / 100ps

module testbench;
  import rtsc_pkg::*;

  // An accepted sample passes the input and the result register on its way out;
  // SETTLE_CYCLES more are allowed before the bench trusts that the pipeline is empty.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 115;
  localparam int HOLD_CYCLES   = 120;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  // Tracks the register copy, predicts each result from the accepted sample
  // and compares it with what comes out of the block.
  class verdict_tracker;
    rule_t       rules [RULE_SLOTS];
    state_map_t  map;
    state_esc_t  sesc;
    action_esc_t aesc;
    result_t     expected_verdicts [$];
    int          errors;
    int          noted;
    int          checked;
    int          state_escalations;
    int          action_escalations;
    int          slot_hits [RULE_SLOTS];
    int          default_hits;

    function new();
      foreach (rules[i]) rules[i] = '0;
      map  = '0;
      sesc = '0;
      aesc = '0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_RULE_0, REG_RULE_1, REG_RULE_2, REG_RULE_3: rules[idx[1:0]] = rule_t'(val[21:0]);
        REG_STATE_MAP:  map  = state_map_t'(val[26:0]);
        REG_STATE_ESC:  sesc = state_esc_t'(val[30:0]);
        REG_ACTION_ESC: aesc = action_esc_t'(val);
        default: ;
      endcase
    endfunction

    // First matching slot picks the base state, then the two escalations.
    function result_t classify(sample_t s);
      int                     v;
      int                     rate;
      int                     lvl;
      logic [STATE_BITS-1:0]  st;
      logic [ACTION_BITS-1:0] act;
      bit                     hit;
      bit                     found;
      result_t                r;
      v     = int'($signed(s.sample_value));
      rate  = v - int'($signed(s.prior_value));
      st    = map.dflt;
      found = 1'b0;
      for (int i = 0; i < RULE_SLOTS; i++) begin
        if (!found) begin
          lvl = int'($signed(rules[i].level));
          case (rules[i].kind)
            KIND_GTE:     hit = v >= lvl;
            KIND_HYST:    hit = (s.prior_state == rules[i].state) && (v > lvl);
            KIND_RATE_GT: hit = rate > lvl;
            KIND_RATE_LT: hit = rate < lvl;
            default:      hit = 1'b0;
          endcase
          if (hit) begin
            st    = rules[i].state;
            found = 1'b1;
            slot_hits[i]++;
          end
        end
      end
      if (!found) default_hits++;
      if (sesc.en && st == sesc.from && s.prior_state == sesc.from &&
          s.time_in_state >= sesc.dur) begin
        st = sesc.to;
        state_escalations++;
      end
      act = (st < STATE_COUNT) ? map.actions[st] : '0;
      if (aesc.en && act == aesc.from && s.time_in_state >= aesc.dur &&
          !(aesc.no_cool && s.cooling_seen)) begin
        act = aesc.to;
        action_escalations++;
      end
      r.new_state     = st;
      r.chosen_action = act;
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_verdicts.push_back(classify(s));
      noted++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: state %0d action %0d", got.new_state,
                   got.chosen_action);
        return;
      end
      want = expected_verdicts.pop_front();
      checked++;
      if (want.new_state !== got.new_state || want.chosen_action !== got.chosen_action) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: expected state %0d action %0d, %s %0d action %0d",
                   checked, want.new_state, want.chosen_action, "got state",
                   got.new_state, got.chosen_action);
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void close_out();
      if (expected_verdicts.size() != 0) begin
        errors++;
        if (errors <= 10)
          $display("%0d expected results never arrived", expected_verdicts.size());
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic [IN_BYTES_BITS-1:0]  s_tdata = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [OUT_BYTES_BITS-1:0] m_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;

  verdict_tracker sb = new();

  // Receiver pacing, owned by the stimulus process and read by the receiver.
  bit rx_stall_en    = 1'b0;
  int pressure_reqs  = 0;
  int pressure_seen  = 0;
  int rx_hold        = 0;
  int rx_wait        = 0;
  int settings_count = 0;

  rule_table_state_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Result side: every accepted beat goes to the tracker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(result_t'(m_tdata[RESULT_BITS-1:0]));
  end

  // Receiver readiness. A pressure request starts one long hold-off, counted
  // here, which lets the block fill up and push back on the sender.
  always @(negedge clk) begin
    if (pressure_reqs != pressure_seen) begin
      pressure_seen = pressure_reqs;
      rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (!rx_stall_en) begin
      m_tready <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_wait = pick_gap();
    end
  end

  function automatic sample_t mk(logic [15:0] v, logic [15:0] p, logic [2:0] ps,
                                 logic [23:0] t, logic c);
    sample_t s;
    s.sample_value  = v;
    s.prior_value   = p;
    s.prior_state   = ps;
    s.time_in_state = t;
    s.cooling_seen  = c;
    return s;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pack_rule(logic [2:0] kind, logic [2:0] st,
                                                         logic [15:0] lvl);
    rule_t r;
    r.kind  = kind;
    r.state = st;
    r.level = lvl;
    return {10'b0, r};
  endfunction

  // Values are steered toward the current levels and escalation durations so
  // that the compare boundaries are hit often; the rest is plain noise.
  function automatic sample_t random_sample();
    sample_t s;
    int k, lvl, v, p, t, need, pick;
    k    = $urandom_range(0, RULE_SLOTS - 1);
    lvl  = int'($signed(sb.rules[k].level));
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      v = $urandom;
      p = $urandom;
    end else if (pick < 5) begin
      v = lvl + int'($urandom_range(0, 6)) - 3;
      p = v + int'($urandom_range(0, 64)) - 32;
    end else if (pick < 8) begin
      v = int'($urandom_range(0, 1024)) - 512;
      p = v - lvl - int'($urandom_range(0, 6)) + 3;
    end else begin
      v = $urandom_range(0, 1) ? 32'h7FFF : -32768;
      p = $urandom_range(0, 1) ? 32'h7FFF : -32768;
    end
    s.sample_value = v[15:0];
    s.prior_value  = p[15:0];
    pick = $urandom_range(0, 9);
    if (pick < 4) s.prior_state = 3'($urandom_range(0, 7));
    else if (pick < 7) s.prior_state = sb.rules[k].state;
    else s.prior_state = sb.sesc.from;
    need = $urandom_range(0, 1) ? int'(sb.sesc.dur) : int'(sb.aesc.dur);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      t = need + int'($urandom_range(0, 4)) - 2;
      if (t < 0) t = 0;
      if (t > 32'hFFFFFF) t = 32'hFFFFFF;
    end else if (pick < 6) begin
      t = $urandom_range(0, 4000);
    end else if (pick < 9) begin
      t = $urandom;
    end else begin
      t = $urandom_range(0, 1) ? 32'hFFFFFF : 0;
    end
    s.time_in_state = t[23:0];
    s.cooling_seen  = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Offer one sample after an optional idle gap; valid stays high when the
  // next beat follows directly.
  task automatic send_sample(input sample_t s, input int gap);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tdata  <= {{(IN_BYTES_BITS - SAMPLE_BITS){1'b0}}, s};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with the pipeline empty.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    rule_t       r;
    state_map_t  m;
    state_esc_t  se;
    action_esc_t ae;
    int          pick;
    for (int k = 0; k < RULE_SLOTS; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) r.kind = KIND_OFF;
      else if (pick == 9) r.kind = 3'($urandom_range(5, 7));
      else r.kind = 3'($urandom_range(KIND_GTE, KIND_RATE_LT));
      r.state = 3'($urandom_range(0, 7));
      r.level = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2048) - 1024);
      write_reg(3'(k), {10'b0, r});
    end
    m = state_map_t'(27'($urandom));
    write_reg(REG_STATE_MAP, {5'b0, m});
    se.en   = $urandom_range(0, 4) != 0;
    se.from = 3'($urandom_range(0, 7));
    se.to   = 3'($urandom_range(0, 7));
    se.dur  = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    write_reg(REG_STATE_ESC, {1'b0, se});
    ae.en      = $urandom_range(0, 4) != 0;
    ae.from    = 3'($urandom_range(0, 7));
    ae.to      = 3'($urandom_range(0, 7));
    ae.no_cool = 1'($urandom_range(0, 1));
    ae.dur     = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    write_reg(REG_ACTION_ESC, ae);
    settings_count++;
  endtask

  initial begin
    state_map_t  dmap;
    state_esc_t  dse;
    action_esc_t dae;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers at their reset value: every slot off, default state zero and
    // no action, whatever the field extremes are.
    send_sample(mk(16'h0000, 16'h0000, 3'd0, 24'd0, 1'b0), 0);
    send_sample(mk(16'h7FFF, 16'h8000, 3'd7, 24'hFFFFFF, 1'b1), 0);
    send_sample(mk(16'h8000, 16'h7FFF, 3'd0, 24'hFFFFFF, 1'b0), 0);
    drain();

    // One slot of each kind, a state escalation out of the hysteresis state
    // and an action escalation out of "no action" that cooling can block.
    write_reg(REG_RULE_0, pack_rule(KIND_GTE, 3'd5, 16'h0400));
    write_reg(REG_RULE_1, pack_rule(KIND_HYST, 3'd3, 16'h0100));
    write_reg(REG_RULE_2, pack_rule(KIND_RATE_GT, 3'd6, 16'h0200));
    write_reg(REG_RULE_3, pack_rule(KIND_RATE_LT, 3'd1, 16'hFE00));
    dmap.dflt    = 3'd2;
    dmap.actions = {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0, 3'd1, 3'd0};
    write_reg(REG_STATE_MAP, {5'b0, dmap});
    dse = '{dur: 24'd1000, to: 3'd4, from: 3'd3, en: 1'b1};
    write_reg(REG_STATE_ESC, {1'b0, dse});
    dae = '{dur: 24'd500, no_cool: 1'b1, to: 3'd7, from: 3'd0, en: 1'b1};
    write_reg(REG_ACTION_ESC, dae);
    settings_count += 2;

    send_sample(mk(16'h0400, 16'h0400, 3'd0, 24'd0, 1'b0), 0);      // level met exactly
    send_sample(mk(16'h03FF, 16'h03FF, 3'd3, 24'd0, 1'b0), 0);      // hysteresis hold
    send_sample(mk(16'h0100, 16'h0100, 3'd3, 24'd0, 1'b0), 0);      // hold needs strictly above
    send_sample(mk(16'h03FF, 16'h03FF, 3'd3, 24'd1000, 1'b0), 0);   // held long enough
    send_sample(mk(16'h03FF, 16'h03FF, 3'd3, 24'd999, 1'b0), 0);    // one below the duration
    send_sample(mk(16'h0300, 16'h0100, 3'd0, 24'd0, 1'b0), 0);      // rate equal to level
    send_sample(mk(16'h0301, 16'h0100, 3'd0, 24'd0, 1'b0), 0);      // rate just above
    send_sample(mk(16'h03FF, 16'h8000, 3'd0, 24'd0, 1'b0), 0);      // positive rate beyond 16-bit range
    send_sample(mk(16'h8000, 16'h7FFF, 3'd0, 24'd0, 1'b0), 0);      // widest negative rate
    send_sample(mk(16'h0000, 16'h0200, 3'd0, 24'd500, 1'b0), 0);    // rate at low level
    send_sample(mk(16'h0000, 16'h0200, 3'd0, 24'd500, 1'b1), 0);    // cooling blocks upgrade
    send_sample(mk(16'h0000, 16'h0200, 3'd0, 24'd499, 1'b0), 0);
    send_sample(mk(16'h0000, 16'h0000, 3'd5, 24'hFFFFFF, 1'b1), 0);
    drain();

    // Unused kind codes never match; extreme register contents throughout.
    write_reg(REG_RULE_0, pack_rule(3'd5, 3'd7, 16'h8000));
    write_reg(REG_RULE_1, 32'h003FFFFF);
    write_reg(REG_RULE_2, pack_rule(3'd6, 3'd2, 16'h8000));
    write_reg(REG_RULE_3, pack_rule(KIND_GTE, 3'd6, 16'h7FFF));
    write_reg(REG_STATE_MAP, 32'h07FFFFFF);
    dse = '{dur: 24'hFFFFFF, to: 3'd0, from: 3'd7, en: 1'b1};
    write_reg(REG_STATE_ESC, {1'b0, dse});
    write_reg(REG_ACTION_ESC, 32'hFFFFFFFF);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    settings_count++;

    send_sample(mk(16'h7FFF, 16'h0000, 3'd7, 24'd0, 1'b0), 0);
    send_sample(mk(16'h7FFE, 16'h8000, 3'd7, 24'hFFFFFF, 1'b1), 0);
    send_sample(mk(16'h8000, 16'h8000, 3'd7, 24'hFFFFFE, 1'b0), 0);
    send_sample(mk(16'h0000, 16'h0000, 3'd7, 24'hFFFFFF, 1'b0), 0);
    drain();

    // Random phases: the first runs without any idling, the third holds the
    // receiver off for a long stretch while the sender keeps pushing.
    for (int ph = 0; ph < PHASES; ph++) begin
      random_config();
      rx_stall_en = (ph != 0);
      if (ph == 2) pressure_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(random_sample(), (ph == 0 || ph == 2) ? 0 : pick_gap());
      drain();
    end

    sb.close_out();
    $display("Covered %0d samples under %0d register settings, %0d results checked.",
             sb.noted, settings_count, sb.checked);
    $display("Slot hits %0d/%0d/%0d/%0d, default %0d, state upgrades %0d, action upgrades %0d.",
             sb.slot_hits[0], sb.slot_hits[1], sb.slot_hits[2], sb.slot_hits[3],
             sb.default_hits, sb.state_escalations, sb.action_escalations);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Run timed out");
    $display("Test completed with failures");
    $finish;
  end

endmodule
